// ----- rtl/core/fqrs_pkg.sv -----
// Shared types, constants and helper functions of the feedback queue scheduler.
`timescale 1ns / 1ps

package fqrs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int NUM_Q       = 3;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = $clog2(NUM_Q * QUEUE_DEPTH);
  localparam int CFG_IDX_W   = 2;

  localparam logic [1:0] Q_ARR  = 2'd0;
  localparam logic [1:0] Q_HIGH = 2'd1;
  localparam logic [1:0] Q_LOW  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_INIT_QUANTUM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_WAIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_WAIT     = 2'd2;

  localparam logic [15:0] RESET_QUANTUM   = 16'd4;
  localparam logic [15:0] RESET_HIGH_WAIT = 16'd100;
  localparam logic [15:0] RESET_LOW_WAIT  = 16'd400;

  localparam logic [3:0] CMD_NOP       = 4'd0;
  localparam logic [3:0] CMD_PUSH_ARR  = 4'd1;
  localparam logic [3:0] CMD_EXPIRE    = 4'd2;
  localparam logic [3:0] CMD_RD        = 4'd3;
  localparam logic [3:0] CMD_AGE       = 4'd4;
  localparam logic [3:0] CMD_AGE_RATIO = 4'd5;
  localparam logic [3:0] CMD_CMP       = 4'd6;
  localparam logic [3:0] CMD_SWAP_A    = 4'd7;
  localparam logic [3:0] CMD_SWAP_B    = 4'd8;
  localparam logic [3:0] CMD_RD_HEAD   = 4'd9;
  localparam logic [3:0] CMD_DISPATCH  = 4'd10;
  localparam logic [3:0] CMD_PROMOTE   = 4'd11;
  localparam logic [3:0] CMD_FINISH    = 4'd12;

  typedef struct packed {
    logic [7:0]  id;
    logic        prio;
    logic [15:0] slots;
    logic [15:0] quantum;
    logic [15:0] age;
  } job_t;

  typedef struct packed {
    logic [3:0]       code;
    logic [1:0]       q;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [NUM_Q-1:0][CNT_W-1:0] counts;
    logic                        running_valid;
    logic                        div_done;
    logic                        best_nonzero;
    logic                        out_free;
  } status_t;

  // Circular slot: base plus offset, wrapped once around the queue depth.
  function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (s >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
      s = s - (CNT_W + 1)'(QUEUE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [1:0] q,
                                                 input logic [IDX_W-1:0] slot);
    return ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);
  endfunction

endpackage

// ----- rtl/core/fqrs_if.sv -----
// Handshake interfaces of the job input channel and the tick result channel.
`timescale 1ns / 1ps

interface fqrs_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  job_id;
  logic        job_priority;
  logic [15:0] job_slots;

  modport source (output valid, op, job_id, job_priority, job_slots, input ready);
  modport sink (input valid, op, job_id, job_priority, job_slots, output ready);
endinterface

interface fqrs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] running_job;
  logic       server_busy;
  logic       all_queues_empty;
  logic       arrival_dropped;

  modport source (output valid, running_job, server_busy, all_queues_empty,
                  arrival_dropped, input ready);
  modport sink (input valid, running_job, server_busy, all_queues_empty,
                arrival_dropped, output ready);
endinterface

// ----- rtl/core/fqrs_divider.sv -----
// Bit-serial restoring divider for the response ratio, one quotient bit a cycle.
`timescale 1ns / 1ps

module fqrs_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [16:0] num,
  input  logic [15:0] den,
  output logic        busy,
  output logic [16:0] quot
);

  logic [15:0] rem;
  logic [15:0] divisor;
  logic [4:0]  steps;
  logic [16:0] trial;
  logic        ge;

  assign trial = {rem, quot[16]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy    <= 1'b1;
      steps   <= 5'd17;
      rem     <= '0;
      quot    <= num;
      divisor <= den;
    end else if (busy) begin
      rem   <= ge ? 16'(trial - {1'b0, divisor}) : trial[15:0];
      quot  <= {quot[15:0], ge};
      steps <= steps - 5'd1;
      if (steps == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/fqrs_datapath.sv -----
// Queue memory, running job, timers, ratio search registers and result register.
`timescale 1ns / 1ps

module fqrs_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  fqrs_pkg::cmd_t                  cmd,
  output fqrs_pkg::status_t               status,
  input  logic [7:0]                      in_job_id,
  input  logic                            in_job_priority,
  input  logic [15:0]                     in_slots,
  input  logic                            cfg_we,
  input  logic [fqrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]                     cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_running_job,
  output logic                            out_server_busy,
  output logic                            out_all_empty,
  output logic                            out_dropped
);

  localparam logic [fqrs_pkg::CNT_W-1:0] FULL = fqrs_pkg::CNT_W'(fqrs_pkg::QUEUE_DEPTH);

  fqrs_pkg::job_t mem [fqrs_pkg::NUM_Q * fqrs_pkg::QUEUE_DEPTH];
  fqrs_pkg::job_t rdata;

  logic [fqrs_pkg::CNT_W-1:0] count [fqrs_pkg::NUM_Q];
  logic [fqrs_pkg::IDX_W-1:0] head  [fqrs_pkg::NUM_Q];

  fqrs_pkg::job_t running;
  logic           running_valid;
  logic [31:0]    run_started;
  logic [31:0]    run_timeout;
  logic [31:0]    tick_count;
  logic           drop_flag;
  logic [15:0]    init_quantum;
  logic [15:0]    high_wait;
  logic [15:0]    low_wait;

  fqrs_pkg::job_t             cur;
  fqrs_pkg::job_t             head_data;
  fqrs_pkg::job_t             best_data;
  logic [fqrs_pkg::IDX_W-1:0] best_idx;
  logic [16:0]                best_r;

  logic                          we;
  logic [fqrs_pkg::ADDR_W-1:0]   waddr;
  fqrs_pkg::job_t                wdata;
  logic [fqrs_pkg::ADDR_W-1:0]   raddr;

  logic                          div_start;
  logic                          div_busy;
  logic [16:0]                   div_quot;
  logic [16:0]                   div_num;

  fqrs_pkg::job_t  aged;
  logic [31:0]     run_len;
  logic [31:0]     elapsed;
  logic            expired;
  logic [15:0]     slots_left;
  logic [16:0]     dq;
  fqrs_pkg::job_t  requeued;
  logic [1:0]      exp_q;
  logic [16:0]     ratio;
  logic            better;
  logic [1:0]      dst_q;
  logic [15:0]     pro_wait;
  logic            pro_ok;
  logic [15:0]     disp_len;
  logic            all_empty;

  always_comb begin
    aged     = rdata;
    aged.age = (rdata.age == 16'hFFFF) ? rdata.age : rdata.age + 16'd1;
    div_num  = 17'({1'b0, aged.age}) + 17'({1'b0, aged.slots}) - 17'd1;
  end

  assign div_start = cmd.code == fqrs_pkg::CMD_AGE_RATIO;

  fqrs_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (aged.slots),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  always_comb begin
    run_len    = run_timeout - run_started;
    elapsed    = tick_count - run_started;
    expired    = running_valid && (elapsed >= run_len);
    slots_left = (elapsed > {16'd0, running.slots}) ? 16'd0 : running.slots - elapsed[15:0];
    dq         = {running.quantum, 1'b0};
    requeued          = running;
    requeued.slots    = slots_left;
    requeued.quantum  = dq[16] ? 16'hFFFF : dq[15:0];
    exp_q      = running.prio ? fqrs_pkg::Q_LOW : fqrs_pkg::Q_HIGH;

    ratio  = (cur.slots == 16'd0) ? 17'd0 : div_quot;
    better = (cmd.idx == '0) || (ratio > best_r) ||
             ((ratio == best_r) && (cur.slots < best_data.slots));

    dst_q    = (cmd.q == fqrs_pkg::Q_LOW) ? fqrs_pkg::Q_HIGH : fqrs_pkg::Q_ARR;
    pro_wait = (cmd.q == fqrs_pkg::Q_LOW) ? low_wait : high_wait;
    pro_ok   = (count[cmd.q] != '0) && (count[dst_q] != FULL) && (rdata.age > pro_wait);

    disp_len  = (rdata.quantum > rdata.slots) ? rdata.slots : rdata.quantum;
    all_empty = (count[fqrs_pkg::Q_ARR] == '0) && (count[fqrs_pkg::Q_HIGH] == '0) &&
                (count[fqrs_pkg::Q_LOW] == '0);
  end

  // Memory port selection.
  always_comb begin
    we    = 1'b0;
    waddr = fqrs_pkg::mem_addr(cmd.q, fqrs_pkg::slot_add(head[cmd.q], fqrs_pkg::CNT_W'(cmd.idx)));
    wdata = aged;
    raddr = waddr;
    case (cmd.code)
      fqrs_pkg::CMD_PUSH_ARR: begin
        we    = count[fqrs_pkg::Q_ARR] != FULL;
        waddr = fqrs_pkg::mem_addr(fqrs_pkg::Q_ARR,
                  fqrs_pkg::slot_add(head[fqrs_pkg::Q_ARR], count[fqrs_pkg::Q_ARR]));
        wdata = '{id: in_job_id, prio: in_job_priority, slots: in_slots,
                  quantum: init_quantum, age: 16'd0};
      end
      fqrs_pkg::CMD_EXPIRE: begin
        we    = expired && (slots_left != 16'd0) && (count[exp_q] != FULL);
        waddr = fqrs_pkg::mem_addr(exp_q, fqrs_pkg::slot_add(head[exp_q], count[exp_q]));
        wdata = requeued;
      end
      fqrs_pkg::CMD_AGE, fqrs_pkg::CMD_AGE_RATIO: begin
        we = 1'b1;
      end
      fqrs_pkg::CMD_SWAP_A: begin
        we    = 1'b1;
        waddr = fqrs_pkg::mem_addr(cmd.q, head[cmd.q]);
        wdata = best_data;
      end
      fqrs_pkg::CMD_SWAP_B: begin
        we    = 1'b1;
        waddr = fqrs_pkg::mem_addr(cmd.q,
                  fqrs_pkg::slot_add(head[cmd.q], fqrs_pkg::CNT_W'(best_idx)));
        wdata = head_data;
      end
      fqrs_pkg::CMD_RD_HEAD: begin
        raddr = fqrs_pkg::mem_addr(cmd.q, head[cmd.q]);
      end
      fqrs_pkg::CMD_PROMOTE: begin
        we    = pro_ok;
        waddr = fqrs_pkg::mem_addr(dst_q, fqrs_pkg::slot_add(head[dst_q], count[dst_q]));
        wdata = rdata;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < fqrs_pkg::NUM_Q; k++) begin
        count[k] <= '0;
        head[k]  <= '0;
      end
      running       <= '0;
      running_valid <= 1'b0;
      run_started   <= '0;
      run_timeout   <= '0;
      tick_count    <= '0;
      drop_flag     <= 1'b0;
      init_quantum  <= fqrs_pkg::RESET_QUANTUM;
      high_wait     <= fqrs_pkg::RESET_HIGH_WAIT;
      low_wait      <= fqrs_pkg::RESET_LOW_WAIT;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.code == fqrs_pkg::CMD_FINISH) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          fqrs_pkg::CFG_INIT_QUANTUM: init_quantum <= cfg_data;
          fqrs_pkg::CFG_HIGH_WAIT:    high_wait    <= cfg_data;
          fqrs_pkg::CFG_LOW_WAIT:     low_wait     <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.code)
        fqrs_pkg::CMD_PUSH_ARR: begin
          if (count[fqrs_pkg::Q_ARR] != FULL) begin
            count[fqrs_pkg::Q_ARR] <= count[fqrs_pkg::Q_ARR] + 1'b1;
          end else begin
            drop_flag <= 1'b1;
          end
        end
        fqrs_pkg::CMD_EXPIRE: begin
          if (expired) begin
            running_valid <= 1'b0;
            if ((slots_left != 16'd0) && (count[exp_q] != FULL)) begin
              count[exp_q] <= count[exp_q] + 1'b1;
            end
          end
        end
        fqrs_pkg::CMD_AGE, fqrs_pkg::CMD_AGE_RATIO: begin
          cur <= aged;
          if (cmd.idx == '0) begin
            head_data <= aged;
          end
        end
        fqrs_pkg::CMD_CMP: begin
          if (better) begin
            best_idx  <= cmd.idx;
            best_r    <= ratio;
            best_data <= cur;
          end
        end
        fqrs_pkg::CMD_DISPATCH: begin
          running       <= rdata;
          running_valid <= 1'b1;
          run_started   <= tick_count;
          run_timeout   <= tick_count + {16'd0, disp_len};
          head[cmd.q]   <= fqrs_pkg::slot_add(head[cmd.q], fqrs_pkg::CNT_W'(1));
          count[cmd.q]  <= count[cmd.q] - 1'b1;
        end
        fqrs_pkg::CMD_PROMOTE: begin
          if (pro_ok) begin
            head[cmd.q]  <= fqrs_pkg::slot_add(head[cmd.q], fqrs_pkg::CNT_W'(1));
            count[cmd.q] <= count[cmd.q] - 1'b1;
            count[dst_q] <= count[dst_q] + 1'b1;
          end
        end
        fqrs_pkg::CMD_FINISH: begin
          out_running_job  <= running_valid ? running.id : 8'd0;
          out_server_busy  <= running_valid;
          out_all_empty    <= all_empty;
          out_dropped      <= drop_flag;
          drop_flag        <= 1'b0;
          tick_count       <= tick_count + 32'd1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < fqrs_pkg::NUM_Q; k++) begin
      status.counts[k] = count[k];
    end
    status.running_valid = running_valid;
    status.div_done      = !div_busy;
    status.best_nonzero  = best_idx != '0;
    status.out_free      = !out_valid || out_ready;
  end

endmodule

// ----- rtl/core/fqrs_ctrl.sv -----
// Tick sequencer: expiry, aging and ratio scan, head swap, dispatch, promotion, result.
`timescale 1ns / 1ps

module fqrs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_ready,
  input  fqrs_pkg::status_t status,
  output fqrs_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LATCH   = 4'd1;
  localparam logic [3:0] S_QBEGIN  = 4'd2;
  localparam logic [3:0] S_AGE     = 4'd3;
  localparam logic [3:0] S_DIV     = 4'd4;
  localparam logic [3:0] S_SWAP_A  = 4'd5;
  localparam logic [3:0] S_SWAP_B  = 4'd6;
  localparam logic [3:0] S_NEXTQ   = 4'd7;
  localparam logic [3:0] S_DISP    = 4'd8;
  localparam logic [3:0] S_DISP2   = 4'd9;
  localparam logic [3:0] S_PRO1    = 4'd10;
  localparam logic [3:0] S_PRO1B   = 4'd11;
  localparam logic [3:0] S_PRO2    = 4'd12;
  localparam logic [3:0] S_PRO2B   = 4'd13;
  localparam logic [3:0] S_FIN     = 4'd14;

  logic [3:0]                 state, state_next;
  logic [1:0]                 q, q_next;
  logic [fqrs_pkg::CNT_W-1:0] i, i_next;
  logic                       idle, idle_next;
  logic [1:0]                 dq, dq_next;
  logic                       ratio_en;
  logic [fqrs_pkg::CNT_W-1:0] qcount;

  assign in_ready = state == S_IDLE;
  assign ratio_en = idle && (q != fqrs_pkg::Q_ARR);
  assign qcount   = status.counts[q];

  always_comb begin
    state_next = state;
    q_next     = q;
    i_next     = i;
    idle_next  = idle;
    dq_next    = dq;
    cmd.code   = fqrs_pkg::CMD_NOP;
    cmd.q      = q;
    cmd.idx    = i[fqrs_pkg::IDX_W-1:0];
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_op) begin
            cmd.code   = fqrs_pkg::CMD_EXPIRE;
            state_next = S_LATCH;
          end else begin
            cmd.code = fqrs_pkg::CMD_PUSH_ARR;
          end
        end
      end
      S_LATCH: begin
        idle_next  = !status.running_valid;
        q_next     = fqrs_pkg::Q_ARR;
        i_next     = '0;
        state_next = S_QBEGIN;
      end
      S_QBEGIN: begin
        if (i < qcount) begin
          cmd.code   = fqrs_pkg::CMD_RD;
          state_next = S_AGE;
        end else if (ratio_en && (qcount != '0) && status.best_nonzero) begin
          state_next = S_SWAP_A;
        end else begin
          state_next = S_NEXTQ;
        end
      end
      S_AGE: begin
        if (ratio_en) begin
          cmd.code   = fqrs_pkg::CMD_AGE_RATIO;
          state_next = S_DIV;
        end else begin
          cmd.code   = fqrs_pkg::CMD_AGE;
          i_next     = i + 1'b1;
          state_next = S_QBEGIN;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.code   = fqrs_pkg::CMD_CMP;
          i_next     = i + 1'b1;
          state_next = S_QBEGIN;
        end
      end
      S_SWAP_A: begin
        cmd.code   = fqrs_pkg::CMD_SWAP_A;
        state_next = S_SWAP_B;
      end
      S_SWAP_B: begin
        cmd.code   = fqrs_pkg::CMD_SWAP_B;
        state_next = S_NEXTQ;
      end
      S_NEXTQ: begin
        i_next = '0;
        if (q == fqrs_pkg::Q_LOW) begin
          state_next = S_DISP;
        end else begin
          q_next     = q + 2'd1;
          state_next = S_QBEGIN;
        end
      end
      S_DISP: begin
        if (!idle) begin
          state_next = S_FIN;
        end else if (status.counts[fqrs_pkg::Q_ARR] != '0) begin
          dq_next = fqrs_pkg::Q_ARR;
        end else if (status.counts[fqrs_pkg::Q_HIGH] != '0) begin
          dq_next = fqrs_pkg::Q_HIGH;
        end else begin
          dq_next = fqrs_pkg::Q_LOW;
        end
        if (idle) begin
          if ((status.counts[fqrs_pkg::Q_ARR] == '0) &&
              (status.counts[fqrs_pkg::Q_HIGH] == '0) &&
              (status.counts[fqrs_pkg::Q_LOW] == '0)) begin
            state_next = S_PRO1;
          end else begin
            cmd.code   = fqrs_pkg::CMD_RD_HEAD;
            cmd.q      = dq_next;
            state_next = S_DISP2;
          end
        end
      end
      S_DISP2: begin
        cmd.code   = fqrs_pkg::CMD_DISPATCH;
        cmd.q      = dq;
        state_next = S_PRO1;
      end
      S_PRO1: begin
        cmd.code   = fqrs_pkg::CMD_RD_HEAD;
        cmd.q      = fqrs_pkg::Q_HIGH;
        state_next = S_PRO1B;
      end
      S_PRO1B: begin
        cmd.code   = fqrs_pkg::CMD_PROMOTE;
        cmd.q      = fqrs_pkg::Q_HIGH;
        state_next = S_PRO2;
      end
      S_PRO2: begin
        cmd.code   = fqrs_pkg::CMD_RD_HEAD;
        cmd.q      = fqrs_pkg::Q_LOW;
        state_next = S_PRO2B;
      end
      S_PRO2B: begin
        cmd.code   = fqrs_pkg::CMD_PROMOTE;
        cmd.q      = fqrs_pkg::Q_LOW;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.code   = fqrs_pkg::CMD_FINISH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      q     <= '0;
      i     <= '0;
      idle  <= 1'b0;
      dq    <= '0;
    end else begin
      state <= state_next;
      q     <= q_next;
      i     <= i_next;
      idle  <= idle_next;
      dq    <= dq_next;
    end
  end

endmodule

// ----- rtl/core/feedback_queue_ratio_scheduler.sv -----
// Top level of the three-queue feedback scheduler with response-ratio selection.
//
//  channel  | dir | beat                                           | yields
//  job_in   | in  | op, job_id, job_priority, job_slots            | arrive or tick
//  result   | out | running_job, server_busy, all_queues_empty,    | one beat per tick
//           |     | arrival_dropped                                |
//  cfg      | in  | cfg_we, cfg_index, cfg_data                    | register write
//
// An arrive beat is pushed into the arrival queue in the cycle it is accepted. A tick reads
// and rewrites each queued entry through the single queue memory, one read and one write an
// entry. With the server idle, each feedback entry also waits on the 17-step serial ratio
// divider before its ratio is compared. Reset is synchronous and needs no clearing pass.
// A stalled result beat holds in the output register; arrivals are still taken, the next
// tick waits in its last step.
`timescale 1ns / 1ps

module feedback_queue_ratio_scheduler (
  input  logic                           clk,
  input  logic                           rst,
  fqrs_in_if.sink                        job_in,
  fqrs_out_if.source                     result,
  input  logic                           cfg_we,
  input  logic [fqrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);

  fqrs_pkg::cmd_t    cmd;
  fqrs_pkg::status_t status;

  fqrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (job_in.valid),
    .in_op    (job_in.op),
    .in_ready (job_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  fqrs_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .in_job_id       (job_in.job_id),
    .in_job_priority (job_in.job_priority),
    .in_slots        (job_in.job_slots),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .out_running_job (result.running_job),
    .out_server_busy (result.server_busy),
    .out_all_empty   (result.all_queues_empty),
    .out_dropped     (result.arrival_dropped)
  );

endmodule

// ----- rtl/core/fqrs_checker.sv -----
// Port-level checks of the scheduler and the bind that attaches them.
`timescale 1ns / 1ps

module fqrs_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_op,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] running_job,
  input logic       server_busy
);

  // A tick walks several sequencer steps, so no second beat is taken next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_op |=> !in_ready)
    else $error("input ready right after a tick beat");

  // An arrival finishes in its own cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_op |=> in_ready)
    else $error("input not ready after an arrival beat");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !server_busy |-> running_job == 8'd0)
    else $error("idle server reports a job id");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

endmodule

bind feedback_queue_ratio_scheduler fqrs_checker u_fqrs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (job_in.valid),
  .in_ready    (job_in.ready),
  .in_op       (job_in.op),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .running_job (result.running_job),
  .server_busy (result.server_busy)
);

// ----- bench/feedback_queue_ratio_scheduler_tb.sv -----
// Self-checking testbench of the feedback queue scheduler against a cycle-free predictor.
`timescale 1ns / 1ps

module feedback_queue_ratio_scheduler_tb;

  localparam logic [fqrs_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;
  localparam int   STALL_LIMIT = 20000;
  localparam int   HOLD_CYCLES = 2500;
  localparam int   TAIL_CYCLES = 60;
  localparam int   PHASE_ITEMS = 195;

  typedef struct packed {
    logic [7:0] running_job;
    logic       server_busy;
    logic       all_queues_empty;
    logic       arrival_dropped;
  } sched_status_t;

  typedef struct {
    int            rep;
    logic          op;
    logic [7:0]    id;
    logic          prio;
    logic [15:0]   slots;
    bit            typed;
    sched_status_t status;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [fqrs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  fqrs_in_if  job_in ();
  fqrs_out_if result ();

  feedback_queue_ratio_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .job_in    (job_in.sink),
    .result    (result.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Predictor state.
  fqrs_pkg::job_t jq[3][$];
  fqrs_pkg::job_t run_job;
  bit          run_on;
  logic [31:0] run_start, run_end, tick_cnt;
  bit          drop_seen;
  logic [15:0] quantum_reg, high_wait_reg, low_wait_reg;

  sched_status_t pending_status[$];
  int errors = 0;
  int src_idle = 0;
  int snk_idle = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // Moves the entry with the best integer response ratio to the head of queue q.
  function automatic void ratio_to_head(input int q);
    int best;
    logic [31:0] r, best_r, num;
    fqrs_pkg::job_t tmp;
    if (jq[q].size() == 0) return;
    best = 0;
    best_r = 0;
    for (int i = 0; i < jq[q].size(); i++) begin
      num = 32'(jq[q][i].age) + 32'(jq[q][i].slots) - 32'd1;
      r = (jq[q][i].slots == 0) ? 32'd0 : num / 32'(jq[q][i].slots);
      if (i == 0 || r > best_r || (r == best_r && jq[q][i].slots < jq[q][best].slots)) begin
        best = i;
        best_r = r;
      end
    end
    tmp = jq[q][0];
    jq[q][0] = jq[q][best];
    jq[q][best] = tmp;
  endfunction

  function automatic void schedule_arrival(input logic [7:0] id, input logic prio,
                                           input logic [15:0] slots);
    fqrs_pkg::job_t j;
    j.id = id;
    j.prio = prio;
    j.slots = slots;
    j.quantum = quantum_reg;
    j.age = 16'd0;
    if (jq[fqrs_pkg::Q_ARR].size() >= fqrs_pkg::QUEUE_DEPTH) drop_seen = 1;
    else jq[fqrs_pkg::Q_ARR] = {jq[fqrs_pkg::Q_ARR], j};
  endfunction

  function automatic sched_status_t schedule_tick();
    logic [31:0] t, len, el, used, dq;
    fqrs_pkg::job_t tmp;
    int tq;
    bit found;
    sched_status_t s;
    t = tick_cnt;
    if (run_on) begin
      len = run_end - run_start;
      el = t - run_start;
      if (el >= len) begin
        used = (el > 32'(run_job.slots)) ? 32'(run_job.slots) : el;
        run_job.slots = run_job.slots - used[15:0];
        if (run_job.slots > 0) begin
          dq = 32'd2 * 32'(run_job.quantum);
          run_job.quantum = (dq > 32'hFFFF) ? 16'hFFFF : dq[15:0];
          tq = run_job.prio ? fqrs_pkg::Q_LOW : fqrs_pkg::Q_HIGH;
          if (jq[tq].size() < fqrs_pkg::QUEUE_DEPTH) jq[tq] = {jq[tq], run_job};
        end
        run_on = 0;
      end
    end
    for (int q = 0; q < 3; q++) begin
      for (int i = 0; i < jq[q].size(); i++) begin
        tmp = jq[q][i];
        if (tmp.age != 16'hFFFF) tmp.age++;
        jq[q][i] = tmp;
      end
    end
    if (!run_on) begin
      ratio_to_head(fqrs_pkg::Q_HIGH);
      ratio_to_head(fqrs_pkg::Q_LOW);
      found = 0;
      for (int q = 0; q < 3; q++) begin
        if (!found && jq[q].size() > 0) begin
          run_job = jq[q][0];
          jq[q].delete(0);
          len = (run_job.quantum > run_job.slots) ? 32'(run_job.slots) : 32'(run_job.quantum);
          run_start = t;
          run_end = t + len;
          run_on = 1;
          found = 1;
        end
      end
      if (jq[fqrs_pkg::Q_HIGH].size() > 0 &&
          jq[fqrs_pkg::Q_ARR].size() < fqrs_pkg::QUEUE_DEPTH &&
          32'(jq[fqrs_pkg::Q_HIGH][0].age) >= 32'(high_wait_reg) + 32'd1) begin
        jq[fqrs_pkg::Q_ARR] = {jq[fqrs_pkg::Q_ARR], jq[fqrs_pkg::Q_HIGH][0]};
        jq[fqrs_pkg::Q_HIGH].delete(0);
      end
      if (jq[fqrs_pkg::Q_LOW].size() > 0 &&
          jq[fqrs_pkg::Q_HIGH].size() < fqrs_pkg::QUEUE_DEPTH &&
          32'(jq[fqrs_pkg::Q_LOW][0].age) >= 32'(low_wait_reg) + 32'd1) begin
        jq[fqrs_pkg::Q_HIGH] = {jq[fqrs_pkg::Q_HIGH], jq[fqrs_pkg::Q_LOW][0]};
        jq[fqrs_pkg::Q_LOW].delete(0);
      end
    end
    s.running_job = run_on ? run_job.id : 8'd0;
    s.server_busy = run_on;
    s.all_queues_empty = (jq[0].size() == 0 && jq[1].size() == 0 && jq[2].size() == 0);
    s.arrival_dropped = drop_seen;
    drop_seen = 0;
    tick_cnt = t + 32'd1;
    return s;
  endfunction

  // Offers one beat, with a random gap first, and predicts it once accepted.
  task automatic send_beat(input logic op, input logic [7:0] id, input logic prio,
                           input logic [15:0] slots, input bit typed,
                           input sched_status_t typed_status);
    sched_status_t s;
    if ($urandom_range(99) < src_idle) begin
      job_in.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < src_idle) @(posedge clk);
    end
    job_in.valid <= 1'b1;
    job_in.op <= op;
    job_in.job_id <= id;
    job_in.job_priority <= prio;
    job_in.job_slots <= slots;
    do @(posedge clk); while (!job_in.ready);
    if (op == OP_ARRIVE) begin
      schedule_arrival(id, prio, slots);
    end else begin
      s = schedule_tick();
      pending_status = {pending_status, (typed ? typed_status : s)};
    end
  endtask

  task automatic write_reg(input logic [fqrs_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      fqrs_pkg::CFG_INIT_QUANTUM: quantum_reg = val;
      fqrs_pkg::CFG_HIGH_WAIT:    high_wait_reg = val;
      fqrs_pkg::CFG_LOW_WAIT:     low_wait_reg = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    job_in.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    int pick;
    logic [15:0] slots;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 5) slots = 16'd0;
      else if (pick < 10) slots = 16'($urandom);
      else if (pick < 12) slots = 16'hFFFF;
      else slots = 16'($urandom_range(1, 12));
      if ($urandom_range(99) < 50)
        send_beat(OP_TICK, 8'($urandom), 1'($urandom), 16'($urandom), 0, '0);
      else
        send_beat(OP_ARRIVE, 8'($urandom), 1'($urandom), slots, 0, '0);
    end
  endtask

  // Result side: checks every accepted beat and throttles ready.
  always @(posedge clk) begin
    sched_status_t want;
    if (!rst && result.valid && result.ready) begin
      if (pending_status.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, actual %p", $time, result.running_job);
      end else begin
        want = pending_status[0];
        pending_status.delete(0);
        if (result.running_job !== want.running_job) begin
          errors++;
          $display("%0t: running_job expected %0d actual %0d", $time, want.running_job,
                   result.running_job);
        end
        if (result.server_busy !== want.server_busy) begin
          errors++;
          $display("%0t: server_busy expected %0b actual %0b", $time, want.server_busy,
                   result.server_busy);
        end
        if (result.all_queues_empty !== want.all_queues_empty) begin
          errors++;
          $display("%0t: all_queues_empty expected %0b actual %0b", $time,
                   want.all_queues_empty, result.all_queues_empty);
        end
        if (result.arrival_dropped !== want.arrival_dropped) begin
          errors++;
          $display("%0t: arrival_dropped expected %0b actual %0b", $time,
                   want.arrival_dropped, result.arrival_dropped);
        end
      end
    end
    if (hold_req) begin
      hold_req = 0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result.ready <= 1'b0;
    end else begin
      result.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  always @(posedge clk) begin
    if ((job_in.valid && job_in.ready) || (result.valid && result.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  stim_row_t stim_table[] = '{
    '{1, OP_TICK,   8'd0,   1'b0, 16'd0,      1, '{8'd0,   1'b0, 1'b1, 1'b0}},
    '{1, OP_ARRIVE, 8'd255, 1'b1, 16'hFFFF,   0, '0},
    '{1, OP_ARRIVE, 8'd0,   1'b0, 16'd0,      0, '0},
    '{1, OP_TICK,   8'd0,   1'b0, 16'd0,      1, '{8'd255, 1'b1, 1'b0, 1'b0}},
    // Fifteen fill the arrival queue, the sixteenth is dropped.
    '{16, OP_ARRIVE, 8'd16, 1'b1, 16'd1,      0, '0},
    '{1, OP_TICK,   8'd0,   1'b1, 16'hFFFF,   1, '{8'd255, 1'b1, 1'b0, 1'b1}},
    '{6, OP_TICK,   8'd0,   1'b0, 16'd0,      0, '0},
    '{1, OP_ARRIVE, 8'hAA,  1'b0, 16'h5555,   0, '0},
    '{1, OP_ARRIVE, 8'h55,  1'b1, 16'hAAAA,   0, '0},
    '{40, OP_TICK,  8'd0,   1'b0, 16'd0,      0, '0}
  };

  initial begin
    job_in.valid = 1'b0;
    job_in.op = OP_ARRIVE;
    job_in.job_id = '0;
    job_in.job_priority = 1'b0;
    job_in.job_slots = '0;
    result.ready = 1'b0;
    run_on = 0;
    run_job = '0;
    run_start = '0;
    run_end = '0;
    tick_cnt = '0;
    drop_seen = 0;
    quantum_reg = fqrs_pkg::RESET_QUANTUM;
    high_wait_reg = fqrs_pkg::RESET_HIGH_WAIT;
    low_wait_reg = fqrs_pkg::RESET_LOW_WAIT;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle = 26;
    snk_idle = 47;
    foreach (stim_table[k]) begin
      for (int r = 0; r < stim_table[k].rep; r++)
        send_beat(stim_table[k].op, stim_table[k].id + 8'(r), stim_table[k].prio,
                  stim_table[k].slots, stim_table[k].typed, stim_table[k].status);
    end
    random_phase(PHASE_ITEMS);
    drain();

    write_reg(fqrs_pkg::CFG_INIT_QUANTUM, 16'd1);
    write_reg(fqrs_pkg::CFG_HIGH_WAIT, 16'd0);
    write_reg(fqrs_pkg::CFG_LOW_WAIT, 16'd0);
    write_reg(CFG_UNUSED, 16'hFFFF);
    cfg_we <= 1'b0;
    src_idle = 47;
    snk_idle = 26;
    // The receiver stalls long enough for ticks to back up behind the output.
    hold_req = 1;
    random_phase(PHASE_ITEMS);
    drain();

    write_reg(fqrs_pkg::CFG_INIT_QUANTUM, 16'hFFFF);
    write_reg(fqrs_pkg::CFG_HIGH_WAIT, 16'hFFFF);
    write_reg(fqrs_pkg::CFG_LOW_WAIT, 16'hFFFF);
    cfg_we <= 1'b0;
    src_idle = 0;
    snk_idle = 0;
    random_phase(PHASE_ITEMS);
    drain();

    write_reg(fqrs_pkg::CFG_INIT_QUANTUM, 16'd0);
    write_reg(fqrs_pkg::CFG_HIGH_WAIT, 16'd3);
    write_reg(fqrs_pkg::CFG_LOW_WAIT, 16'd10);
    cfg_we <= 1'b0;
    src_idle = 26;
    snk_idle = 47;
    random_phase(PHASE_ITEMS / 2);
    drain();

    write_reg(fqrs_pkg::CFG_INIT_QUANTUM, 16'($urandom_range(1, 6)));
    write_reg(fqrs_pkg::CFG_HIGH_WAIT, 16'($urandom_range(0, 30)));
    write_reg(fqrs_pkg::CFG_LOW_WAIT, 16'($urandom_range(0, 60)));
    cfg_we <= 1'b0;
    src_idle = 0;
    snk_idle = 0;
    random_phase(PHASE_ITEMS / 2);
    drain();

    if (errors == 0 && pending_status.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
